// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. Each use names a label, an
// antecedent, a consequent and a message. All are clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Types and constant tables for the MD5 hash engine: sequencer states,
// initial chaining words, per-round additive constants and rotate amounts.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef logic [31:0] t_word;

    // Initial chaining words A, B, C, D
    localparam t_word INIT_A = 32'h67452301;
    localparam t_word INIT_B = 32'hefcdab89;
    localparam t_word INIT_C = 32'h98badcfe;
    localparam t_word INIT_D = 32'h10325476;

    // Padding marker byte and buffer positions
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN  = 6'd56;

    // Round groups
    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;

    // Additive constant of round i
    function automatic t_word round_const(input logic [5:0] i);
        t_word k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left-rotate amount by round group and round index within a quad
    function automatic logic [4:0] rot_amount(input logic [1:0] grp,
                                              input logic [1:0] sub);
        logic [4:0] s;
        case ({grp, sub})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // 32-bit left rotate
    function automatic t_word rotl(input t_word x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/md5_hash_engine.sv =====
// ----------------------------------------------------------------------------
// md5_hash_engine
// MD5 digest of a byte stream, one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream (s_axis): one item per message byte (tuser = 0, byte in
//  tdata) or a finish item (tuser = 1, tdata ignored).
//  Output stream (m_axis): after a finish, four digest words A, B, C, D,
//  digest bytes low byte first in each word; tlast marks word D.
//  Flow: a data byte is written into the block buffer when accepted. The
//  64th byte of a block starts compression: 64 rounds through the single
//  round unit, then a fold of the working words into the chaining words.
//  A finish at block position p writes the padding one byte per cycle,
//  compresses, and when p >= 56 pads and compresses a second block; the
//  four words then follow one per accepted cycle. The input is not ready
//  while a block is compressed, padding is written or the digest is out.
//  A stalled receiver holds the current word.
//  Reset (synchronous, active low) restores the initial chaining words and
//  clears the byte count; the block buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module md5_hash_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] req_type (1 = finish)
    // digest stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] digest_word
    output logic             o_m_axis_tlast    // last_word
);

    import md5_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state       r_state, n_state;
    logic [63:0]  r_count, n_count;      // message byte count
    logic [63:0]  r_len,   n_len;        // bit length latched at finish
    logic [5:0]   r_wpos,  n_wpos;       // padding write position
    logic         r_extra, n_extra;      // length spills into a second block
    logic         r_final, n_final;      // finish in progress
    logic [5:0]   r_rnd,   n_rnd;        // round index
    logic [1:0]   r_oidx,  n_oidx;       // digest word index
    t_word        r_a, r_b, r_c, r_d;
    t_word        n_a, n_b, n_c, n_d;
    t_word        r_chain [4];
    t_word        n_chain [4];
    t_word        r_buf [16];            // block buffer, 16 little-endian words

    // Buffer write port
    logic         w_we;
    logic [5:0]   w_addr;
    logic [7:0]   w_byte;

    // Round unit
    logic [1:0]   w_grp;
    logic [3:0]   w_i4;
    logic [3:0]   w_g;
    t_word        w_f;
    t_word        w_sum;
    t_word        w_t;

    logic         w_s_acc;
    logic         w_m_acc;

    assign w_s_acc = i_s_axis_tvalid & o_s_axis_tready;
    assign w_m_acc = o_m_axis_tvalid & i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = r_chain[r_oidx];
    assign o_m_axis_tlast  = (r_oidx == 2'd3);

    // ------------------------------------------------------------------
    // Round unit: f, message index g, one MD5 step
    // ------------------------------------------------------------------
    assign w_grp = r_rnd[5:4];
    assign w_i4  = r_rnd[3:0];

    always_comb begin
        case (w_grp)
            GRP_F: begin
                w_f = (r_b & r_c) | (~r_b & r_d);
                w_g = w_i4;
            end
            GRP_G: begin
                w_f = (r_b & r_d) | (r_c & ~r_d);
                w_g = 4'(w_i4 * 4'd5 + 4'd1);
            end
            GRP_H: begin
                w_f = r_b ^ r_c ^ r_d;
                w_g = 4'(w_i4 * 4'd3 + 4'd5);
            end
            default: begin
                w_f = r_c ^ (r_b | ~r_d);
                w_g = 4'(w_i4 * 4'd7);
            end
        endcase
    end

    assign w_sum = r_a + w_f + r_buf[w_g] + round_const(r_rnd);
    assign w_t   = r_b + rotl(w_sum, rot_amount(w_grp, r_rnd[1:0]));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_len   = r_len;
        n_wpos  = r_wpos;
        n_extra = r_extra;
        n_final = r_final;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        n_chain = r_chain;
        w_we    = 1'b0;
        w_addr  = r_wpos;
        w_byte  = 8'h00;

        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    w_we   = 1'b1;
                    w_addr = r_count[5:0];
                    if (!i_s_axis_tuser) begin
                        // message byte
                        w_byte  = i_s_axis_tdata;
                        n_count = r_count + 64'd1;
                    end else begin
                        // finish: marker byte, latch bit length
                        w_byte  = PAD_MARK;
                        n_len   = {r_count[60:0], 3'b000};
                        n_final = 1'b1;
                        n_extra = (r_count[5:0] >= POS_LEN);
                        n_wpos  = r_count[5:0] + 6'd1;
                    end
                    if (r_count[5:0] == POS_LAST) begin
                        n_state = S_ROUND;
                        n_rnd   = 6'd0;
                        n_a     = r_chain[0];
                        n_b     = r_chain[1];
                        n_c     = r_chain[2];
                        n_d     = r_chain[3];
                    end else if (i_s_axis_tuser) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // zeros, then the length bytes in the block that carries them
                w_we   = 1'b1;
                w_addr = r_wpos;
                if (r_wpos >= POS_LEN && !r_extra) begin
                    w_byte = r_len[{r_wpos[2:0], 3'b000} +: 8];
                end
                n_wpos = r_wpos + 6'd1;
                if (r_wpos == POS_LAST) begin
                    n_state = S_ROUND;
                    n_rnd   = 6'd0;
                    n_a     = r_chain[0];
                    n_b     = r_chain[1];
                    n_c     = r_chain[2];
                    n_d     = r_chain[3];
                end
            end
            S_ROUND: begin
                n_a   = r_d;
                n_d   = r_c;
                n_c   = r_b;
                n_b   = w_t;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == POS_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                if (!r_final) begin
                    n_state = S_IDLE;
                end else if (r_extra) begin
                    // second padding block
                    n_extra = 1'b0;
                    n_wpos  = 6'd0;
                    n_state = S_PAD;
                end else begin
                    n_oidx  = 2'd0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_m_acc) begin
                    n_oidx = r_oidx + 2'd1;
                    if (o_m_axis_tlast) begin
                        n_chain[0] = INIT_A;
                        n_chain[1] = INIT_B;
                        n_chain[2] = INIT_C;
                        n_chain[3] = INIT_D;
                        n_count    = 64'd0;
                        n_final    = 1'b0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= 64'd0;
            r_extra    <= 1'b0;
            r_final    <= 1'b0;
            r_oidx     <= 2'd0;
            r_chain[0] <= INIT_A;
            r_chain[1] <= INIT_B;
            r_chain[2] <= INIT_C;
            r_chain[3] <= INIT_D;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_extra <= n_extra;
            r_final <= n_final;
            r_oidx  <= n_oidx;
            r_chain <= n_chain;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_wpos <= n_wpos;
        r_rnd  <= n_rnd;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
    end

    // Block buffer byte write
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_buf[w_addr[5:2]][{w_addr[1:0], 3'b000} +: 8] <= w_byte;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_SAME(a_no_overlap, o_s_axis_tready, !o_m_axis_tvalid, "input ready during digest")
    `ASSERT_NEXT(a_block_full,
        w_s_acc && !i_s_axis_tuser && r_count[5:0] == POS_LAST,
        r_state == S_ROUND, "full block did not start rounds")
    `ASSERT_NEXT(a_round_end, r_state == S_ROUND && r_rnd == POS_LAST,
        r_state == S_FOLD, "rounds did not end in fold")
    `ASSERT_NEXT(a_restart, w_m_acc && o_m_axis_tlast,
        r_state == S_IDLE && r_count == 64'd0 && r_chain[0] == INIT_A,
        "state not restarted after digest")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of md5_hash_engine. Message bytes and finish items go in with
// random gaps; a digest scoreboard hashes the same accepted items and checks
// each digest word and its tlast flag as it comes out under random stalls.
// ----------------------------------------------------------------------------

module tb_top;

    import md5_pkg::*;

    // Item kinds carried in tuser
    localparam bit REQ_DATA   = 1'b0;
    localparam bit REQ_FINISH = 1'b1;

    localparam int IDLE_LIMIT  = 2000;   // cycles with no item moved on either side
    localparam int DRAIN_WAIT  = 300;
    localparam int TOTAL_ITEMS = 150;
    localparam int CALM_AFTER  = 125;    // no idling once this many items are in

    // Message lengths around block and padding boundaries
    localparam int LONG_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    // Per-round additive constants
    localparam bit [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, four per round group
    localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

    // Digest scoreboard: hashes accepted items and holds the words still due
    class digest_board;
        t_word     chain [4];
        bit [7:0]  blk [64];
        bit [63:0] nbytes;
        bit [32:0] words_due [$];   // {last_word, digest_word}
        int        fails;

        function new();
            restart();
            foreach (blk[i]) blk[i] = 8'h00;
            fails = 0;
        endfunction

        function void restart();
            chain[0] = INIT_A;
            chain[1] = INIT_B;
            chain[2] = INIT_C;
            chain[3] = INIT_D;
            nbytes = 64'd0;
        endfunction

        function t_word rol(t_word v, int k);
            return (v << k) | (v >> (32 - k));
        endfunction

        // One 64-round compression of blk into chain
        function void compress();
            t_word m [16];
            t_word a, b, c, d, f, t;
            int    g;
            for (int i = 0; i < 16; i++)
                m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++) begin
                case (i / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        g = (5 * i + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                t = b + rol(a + f + m[g] + ROUND_K[i], ROT_AMT[(i / 16) * 4 + i % 4]);
                a = d;
                d = c;
                c = b;
                b = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        // Accepted input item
        function void note_item(bit req, bit [7:0] b);
            int        p;
            bit [63:0] bits;
            p = int'(nbytes[5:0]);
            if (req == REQ_DATA) begin
                blk[p] = b;
                nbytes += 64'd1;
                if (p == 63)
                    compress();
                return;
            end
            // finish: marker, zeros, bit length, maybe an extra block
            blk[p] = 8'h80;
            p++;
            if (p > 56) begin
                for (int i = p; i < 64; i++) blk[i] = 8'h00;
                compress();
                p = 0;
            end
            for (int i = p; i < 56; i++) blk[i] = 8'h00;
            bits = nbytes << 3;
            for (int i = 0; i < 8; i++) blk[56+i] = bits[8*i +: 8];
            compress();
            for (int i = 0; i < 4; i++)
                words_due.push_back({(i == 3), chain[i]});
            restart();
        endfunction

        // Accepted output item
        function void check_word(t_word w, bit l);
            bit [32:0] due;
            if (words_due.size() == 0) begin
                $error("digest_word: unexpected item, actual %08h last_word %0b", w, l);
                fails++;
                return;
            end
            due = words_due.pop_front();
            if (w !== due[31:0]) begin
                $error("digest_word: expected %08h, actual %08h", due[31:0], w);
                fails++;
            end
            if (l !== due[32]) begin
                $error("last_word: expected %0b, actual %0b", due[32], l);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        i_s_axis_tuser = 1'b0;    // [0] req_type
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;           // [31:0] digest_word
    logic        o_m_axis_tlast;

    digest_board sb = new();
    bit          calm = 1'b0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          rdy_left = 0;

    md5_hash_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Monitor both sides, watchdog, and receiver stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_item(i_s_axis_tuser, i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_word(o_m_axis_tdata, o_m_axis_tlast);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
        if (rdy_left == 0) begin
            if (calm) begin
                i_m_axis_tready <= 1'b1;
                rdy_left = 1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                rdy_left = $urandom_range(1, 18);
            end else begin
                i_m_axis_tready <= 1'b1;
                rdy_left = $urandom_range(1, 30);
            end
        end
        rdy_left--;
    end

    // Present one item, after an optional gap, and wait until it is taken
    task automatic send_item(input bit req, input bit [7:0] b);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= req;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        if (items_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    // Random message of len bytes; tdata on the finish item is junk
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_item(REQ_DATA, 8'($urandom_range(0, 255)));
        send_item(REQ_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Stimulus
    initial begin
        int left;
        int msg_no;
        int len;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, stray tdata on finish
        send_item(REQ_FINISH, 8'hff);
        // single byte extremes
        send_item(REQ_DATA, 8'h00);
        send_item(REQ_FINISH, 8'h00);
        send_item(REQ_DATA, 8'hff);
        send_item(REQ_FINISH, 8'h5a);
        // "abc"
        send_item(REQ_DATA, 8'h61);
        send_item(REQ_DATA, 8'h62);
        send_item(REQ_DATA, 8'h63);
        send_item(REQ_FINISH, 8'($urandom_range(0, 255)));
        // alternating bits
        send_item(REQ_DATA, 8'h55);
        send_item(REQ_DATA, 8'haa);
        send_item(REQ_FINISH, 8'h80);
        // back-to-back empty messages
        send_item(REQ_FINISH, 8'h01);
        send_item(REQ_FINISH, 8'hfe);

        // Random messages: the first few drawn from lengths around block
        // and padding boundaries, some of which push the padding into an extra
        // block; the last one is cut short so the item total stays fixed
        msg_no = 0;
        while (items_sent < TOTAL_ITEMS) begin
            left = TOTAL_ITEMS - items_sent;
            if (msg_no < 3 || $urandom_range(0, 7) == 0)
                len = LONG_LENS[$urandom_range(0, 9)];
            else
                len = $urandom_range(0, 20);
            if (len >= left)
                len = left - 1;
            send_message(len);
            msg_no++;
        end
        calm = 1'b1;
        i_s_axis_tvalid <= 1'b0;

        // Drain
        while (sb.words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.fails == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
